// ===== src/csl_pkg.sv =====
// csl_pkg: shared types, codes and constants of the small C lexer.
// Used by the step unit and the top level.
`timescale 1ns / 1ps
package csl_pkg;
  localparam int unsigned LookaheadDepthDef = 7;
  localparam int unsigned PositionBitsDef   = 16;
  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;
  localparam logic [15:0] LenMax = 16'hFFFF;

  typedef enum logic [3:0] {
    KIND_OP = 4'd0, KIND_NUM = 4'd1, KIND_ID = 4'd2, KIND_IF = 4'd3,
    KIND_ELSE = 4'd4, KIND_WHILE = 4'd5, KIND_RETURN = 4'd6, KIND_END = 4'd7,
    KIND_INVALID = 4'd8, KIND_ILLEGAL = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    OP_EQ = 4'd0, OP_NE = 4'd1, OP_LE = 4'd2, OP_GE = 4'd3, OP_ASSIGN = 4'd4,
    OP_PLUS = 4'd5, OP_MINUS = 4'd6, OP_MUL = 4'd7, OP_DIV = 4'd8,
    OP_LPAR = 4'd9, OP_RPAR = 4'd10, OP_LT = 4'd11, OP_GT = 4'd12, OP_SEMI = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0, MODE_NUM = 2'd1, MODE_ID = 2'd2, MODE_ERR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_EMIT, ST_TAIL, ST_ENDTOK
  } state_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic [30:0] value;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction
  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == 8'h5F;
  endfunction
  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction
  function automatic logic [7:0] kw_char(input logic [1:0] j, input logic [2:0] i);
    logic [47:0] s;
    case (j)
      2'd0:    s = {"if", 32'h0};
      2'd1:    s = {"else", 16'h0};
      2'd2:    s = {"while", 8'h0};
      default: s = "return";
    endcase
    return s[47 - 8 * i -: 8];
  endfunction
  function automatic logic [2:0] kw_len(input logic [1:0] j);
    case (j)
      2'd0:    return 3'd2;
      2'd1:    return 3'd4;
      2'd2:    return 3'd5;
      default: return 3'd6;
    endcase
  endfunction
endpackage

// ===== src/csl_step.sv =====
// csl_step: one scan step over the head of the byte queue.
// Depends on csl_pkg. Pure combinational decision shared by every step.
`timescale 1ns / 1ps
module csl_step
  import csl_pkg::*;
#(
  parameter int unsigned QCap = LookaheadDepthDef + 1,
  localparam int unsigned QW = $clog2(QCap + 1)
) (
  input  logic [QCap-1:0][7:0] q_i,
  input  logic [QW-1:0]        n_i,
  input  logic                 fin_i,
  input  mode_e                mode_i,
  input  logic [15:0]          pos_i,
  input  logic [30:0]          acc_i,
  input  logic [15:0]          tstart_i,
  input  logic [15:0]          tlen_i,
  output logic                 stop_o,
  output logic [2:0]           adv_o,
  output logic                 emit_o,
  output token_t               tok_o,
  output mode_e                mode_o,
  output logic [30:0]          acc_o,
  output logic                 set_start_o,
  output logic [15:0]          tlen_o
);
  logic [7:0]  b;
  logic [34:0] mul;
  logic [35:0] sum;
  logic [1:0]  j;
  logic        has_kw;
  logic [1:0]  kr;
  logic [2:0]  kl;
  logic [15:0] len_inc;

  assign b       = q_i[0];
  assign mul     = {1'b0, acc_i, 3'b0} + {3'b0, acc_i, 1'b0};
  assign sum     = {1'b0, mul} + {28'd0, b - 8'h30};
  assign len_inc = (tlen_i == LenMax) ? tlen_i : tlen_i + 16'd1;

  always_comb begin
    has_kw = 1'b1;
    case (b)
      "i":     j = 2'd0;
      "e":     j = 2'd1;
      "w":     j = 2'd2;
      "r":     j = 2'd3;
      default: begin j = 2'd0; has_kw = 1'b0; end
    endcase
    kl = kw_len(j);
    // 0 no match, 1 match, 2 need more
    kr = 2'd1;
    for (int i = 0; i < 6; i++) begin
      if (kr == 2'd1 && 3'(i) < kl) begin
        if (QW'(i) >= n_i) kr = fin_i ? 2'd0 : 2'd2;
        else if (q_i[i] != kw_char(j, 3'(i))) kr = 2'd0;
      end
    end
    if (kr == 2'd1 && j == 2'd3) begin
      if (n_i > QW'(6)) kr = is_word(q_i[6]) ? 2'd0 : 2'd1;
      else kr = fin_i ? 2'd1 : 2'd2;
    end
    if (!has_kw) kr = 2'd0;
  end

  always_comb begin
    stop_o = 1'b0;
    adv_o = 3'd0;
    emit_o = 1'b0;
    tok_o = '0;
    tok_o.start = pos_i;
    mode_o = mode_i;
    acc_o = acc_i;
    set_start_o = 1'b0;
    tlen_o = tlen_i;
    case (mode_i)
      MODE_NUM: begin
        if (is_digit(b)) begin
          acc_o = (sum > {5'd0, NumMax}) ? NumMax : sum[30:0];
          tlen_o = len_inc;
          adv_o = 3'd1;
        end else begin
          emit_o = 1'b1;
          tok_o.kind = KIND_NUM;
          tok_o.value = acc_i;
          tok_o.start = tstart_i;
          tok_o.len = tlen_i;
          mode_o = MODE_IDLE;
        end
      end
      MODE_ID: begin
        if (b inside {" ", ";", "+", "-", "*", "/", "(", ")", "<", ">", "=", "!"}) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_ID;
          tok_o.start = tstart_i;
          tok_o.len = tlen_i;
          mode_o = MODE_IDLE;
        end else if (b inside {"@", ":", "$", "#", "&"}) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_ILLEGAL;
          tok_o.last = 1'b1;
          mode_o = MODE_ERR;
          adv_o = 3'd1;
        end else begin
          tlen_o = len_inc;
          adv_o = 3'd1;
        end
      end
      MODE_ERR: adv_o = 3'd1;
      default: begin
        if (is_space(b)) begin
          adv_o = 3'd1;
        end else if (b inside {"=", "!", "<", ">"}) begin
          if (n_i < QW'(2) && !fin_i) begin
            stop_o = 1'b1;
          end else if (n_i >= QW'(2) && q_i[1] == "=") begin
            emit_o = 1'b1;
            tok_o.len = 16'd2;
            case (b)
              "=":     tok_o.op = OP_EQ;
              "!":     tok_o.op = OP_NE;
              "<":     tok_o.op = OP_LE;
              default: tok_o.op = OP_GE;
            endcase
            adv_o = 3'd2;
          end else if (b == "!") begin
            emit_o = 1'b1;
            tok_o.kind = KIND_INVALID;
            tok_o.last = 1'b1;
            mode_o = MODE_ERR;
            adv_o = 3'd1;
          end else begin
            emit_o = 1'b1;
            tok_o.len = 16'd1;
            case (b)
              "=":     tok_o.op = OP_ASSIGN;
              "<":     tok_o.op = OP_LT;
              default: tok_o.op = OP_GT;
            endcase
            adv_o = 3'd1;
          end
        end else if (b inside {"+", "-", "*", "/", "(", ")", ";"}) begin
          emit_o = 1'b1;
          tok_o.len = 16'd1;
          case (b)
            "+":     tok_o.op = OP_PLUS;
            "-":     tok_o.op = OP_MINUS;
            "*":     tok_o.op = OP_MUL;
            "/":     tok_o.op = OP_DIV;
            "(":     tok_o.op = OP_LPAR;
            ")":     tok_o.op = OP_RPAR;
            default: tok_o.op = OP_SEMI;
          endcase
          adv_o = 3'd1;
        end else if (is_digit(b)) begin
          mode_o = MODE_NUM;
          acc_o = {23'd0, b - 8'h30};
          set_start_o = 1'b1;
          tlen_o = 16'd1;
          adv_o = 3'd1;
        end else if (is_alpha(b) || b == "_") begin
          if (kr == 2'd2) begin
            stop_o = 1'b1;
          end else if (kr == 2'd1) begin
            emit_o = 1'b1;
            tok_o.kind = 4'(3 + j);
            tok_o.len = {13'd0, kl};
            adv_o = kl;
          end else begin
            mode_o = MODE_ID;
            set_start_o = 1'b1;
            tlen_o = 16'd1;
            adv_o = 3'd1;
          end
        end else begin
          emit_o = 1'b1;
          tok_o.kind = KIND_INVALID;
          tok_o.last = 1'b1;
          mode_o = MODE_ERR;
          adv_o = 3'd1;
        end
      end
    endcase
  end
endmodule

// ===== src/c_subset_lexer.sv =====
// c_subset_lexer: top level, byte queue, sequencer and output register.
// Depends on csl_pkg and csl_step.
//
// Usage: source bytes enter on the text channel (text_byte_i, end_mark_i with
// valid/ready); tokens leave on the token channel, one field per port.
// Each accepted word is loaded into a queue together with up to
// LOOKAHEAD_DEPTH held bytes, and the shared step unit then takes one scan
// step per cycle while not stalled. A step that emits a token waits in the
// output register until the receiver takes it; an emitting step stalls
// while that register is full and not being taken. An item is loaded in
// idle and scanned step by step, then the sequencer returns to idle; a step
// that closes a number or identifier advances no byte. An end word then
// passes the tail and end-token states, which also wait on the register.
// in_ready_o is high only while the sequencer is idle.
// Reset clears the control and position state, not the queue or token
// register; the next byte has offset 0. An end word emits any pending token
// and, unless the run ended in error, the end token, then clears scan state.
`timescale 1ns / 1ps
module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int unsigned LOOKAHEAD_DEPTH = LookaheadDepthDef,
  parameter int unsigned POSITION_BITS   = PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [3:0]  operator_code_o,
  output logic [30:0] number_value_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        run_last_o
);
  localparam int unsigned QCap = LOOKAHEAD_DEPTH + 1;
  localparam int unsigned QW   = $clog2(QCap + 1);
  localparam int unsigned PB   = POSITION_BITS;
  localparam logic [PB-1:0] PosMax = '1;

  state_e st_q, st_d;
  logic [QCap-1:0][7:0] q_q, q_d;
  logic [QCap-1:0][PB-1:0] p_q, p_d;
  logic [QW-1:0] n_q, n_d;
  logic fin_q, fin_d;
  mode_e mode_q, mode_d;
  logic [30:0] acc_q, acc_d;
  logic [PB-1:0] tstart_q, tstart_d, bpos_q, bpos_d;
  logic [15:0] tlen_q, tlen_d;
  logic [QW-1:0] la_n_q, la_n_d;
  logic [LOOKAHEAD_DEPTH-1:0][7:0] la_q, la_d;
  token_t tok_q, tok_d;
  logic ov_q, ov_d;

  logic s_stop, s_emit, s_set;
  logic [2:0] s_adv;
  token_t s_tok;
  mode_e s_mode;
  logic [30:0] s_acc;
  logic [15:0] s_tlen;
  logic [QCap-1:0][15:0] p16;

  always_comb
    for (int i = 0; i < QCap; i++) p16[i] = 16'(p_q[i]);

  csl_step #(.QCap(QCap)) u_step (
    .q_i(q_q), .n_i(n_q), .fin_i(fin_q), .mode_i(mode_q), .pos_i(p16[0]),
    .acc_i(acc_q), .tstart_i(16'(tstart_q)), .tlen_i(tlen_q),
    .stop_o(s_stop), .adv_o(s_adv), .emit_o(s_emit), .tok_o(s_tok),
    .mode_o(s_mode), .acc_o(s_acc), .set_start_o(s_set), .tlen_o(s_tlen)
  );

  function automatic logic [PB-1:0] padd(input logic [PB-1:0] a, input logic [QW-1:0] k);
    logic [PB:0] s;
    s = {1'b0, a} + (PB + 1)'(k);
    return s[PB] ? PosMax : s[PB-1:0];
  endfunction

  assign in_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign token_kind_o = tok_q.kind;
  assign operator_code_o = tok_q.op;
  assign number_value_o = tok_q.value;
  assign start_offset_o = tok_q.start;
  assign token_length_o = tok_q.len;
  assign run_last_o = tok_q.last;

  always_comb begin
    logic busy;
    logic [QW-1:0] cnt;
    st_d = st_q; q_d = q_q; p_d = p_q; n_d = n_q; fin_d = fin_q;
    mode_d = mode_q; acc_d = acc_q; tstart_d = tstart_q; tlen_d = tlen_q;
    bpos_d = bpos_q; la_n_d = la_n_q; la_d = la_q; tok_d = tok_q;
    ov_d = ov_q && !out_ready_i;
    busy = ov_q && !out_ready_i;
    cnt = (mode_q == MODE_IDLE) ? la_n_q : '0;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          for (int i = 0; i < QCap; i++) begin
            q_d[i] = (QW'(i) < cnt) ? la_q[i] : text_byte_i;
            p_d[i] = (QW'(i) < cnt) ? padd(tstart_q, QW'(i)) : bpos_q;
          end
          n_d = end_mark_i ? cnt : cnt + QW'(1);
          fin_d = end_mark_i;
          if (!end_mark_i) bpos_d = padd(bpos_q, QW'(1));
          la_n_d = '0;
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (n_q == '0 || s_stop) begin
          if (s_stop && mode_q == MODE_IDLE) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) la_d[i] = q_q[i];
            la_n_d = (n_q > QW'(LOOKAHEAD_DEPTH)) ? QW'(LOOKAHEAD_DEPTH) : n_q;
            tstart_d = p_q[0];
          end
          st_d = fin_q ? ST_TAIL : ST_IDLE;
        end else if (!(s_emit && busy)) begin
          if (s_emit) begin
            tok_d = s_tok;
            ov_d = 1'b1;
          end
          mode_d = s_mode;
          acc_d = s_acc;
          tlen_d = s_tlen;
          if (s_set) tstart_d = p_q[0];
          for (int i = 0; i < QCap; i++) begin
            for (int k = 0; i + k < QCap; k++) begin
              if (int'(s_adv) == k) begin
                q_d[i] = q_q[i + k];
                p_d[i] = p_q[i + k];
              end
            end
          end
          n_d = n_q - QW'(s_adv);
        end
      end
      ST_TAIL: begin
        if (!busy) begin
          tok_d = '0;
          tok_d.start = 16'(tstart_q);
          tok_d.len = tlen_q;
          if (mode_q == MODE_NUM) begin
            tok_d.kind = KIND_NUM; tok_d.value = acc_q; ov_d = 1'b1;
          end else if (mode_q == MODE_ID) begin
            tok_d.kind = KIND_ID; ov_d = 1'b1;
          end
          st_d = ST_ENDTOK;
        end
      end
      ST_ENDTOK: begin
        if (!busy) begin
          if (mode_q != MODE_ERR) begin
            tok_d = '0;
            tok_d.kind = KIND_END;
            tok_d.start = 16'(bpos_q);
            tok_d.last = 1'b1;
            ov_d = 1'b1;
          end
          mode_d = MODE_IDLE; acc_d = '0; tstart_d = '0; tlen_d = '0;
          bpos_d = '0; la_n_d = '0; la_d = '0;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      mode_q <= MODE_IDLE;
      acc_q <= '0;
      tstart_q <= '0;
      tlen_q <= '0;
      bpos_q <= '0;
      la_n_q <= '0;
      la_q <= '0;
      ov_q <= 1'b0;
      n_q <= '0;
      fin_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mode_q <= mode_d;
      acc_q <= acc_d;
      tstart_q <= tstart_d;
      tlen_q <= tlen_d;
      bpos_q <= bpos_d;
      la_n_q <= la_n_d;
      la_q <= la_d;
      ov_q <= ov_d;
      n_q <= n_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    p_q <= p_d;
    tok_q <= tok_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_q == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tok_q))
    else $error("token dropped under stall");
  a_la_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_n_q <= QW'(LOOKAHEAD_DEPTH)) else $error("lookahead overflow");
  a_end_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_ENDTOK && !(ov_q && !out_ready_i) |=> bpos_q == '0)
    else $error("position not cleared at end");
endmodule

// ===== tb/tb_c_subset_lexer.sv =====
// tb_c_subset_lexer: self-checking testbench of the small C lexer.
// Feeds source bytes and end words, predicts tokens with a local scanner model
// and compares every token field by field. Depends on csl_pkg and c_subset_lexer.
`timescale 1ns / 1ps
module tb_c_subset_lexer;
  import csl_pkg::*;

  localparam int PosMax = 65535;
  localparam int HoldDepth = 7;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic [30:0] value;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'h00;
  logic        end_mark_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [3:0]  operator_code_o;
  logic [30:0] number_value_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic        run_last_o;

  c_subset_lexer u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  tok_t tok_q[$];
  int   n_err = 0;
  int   n_cyc = 0;

  // scanner model state
  logic [7:0] held_b[HoldDepth];
  int         held_n = 0;
  mode_e      mode = MODE_IDLE;
  int         acc = 0;
  int         t_start = 0;
  int         t_len = 0;
  int         pos = 0;

  function automatic int sat_add(int p, int k);
    return (p + k > PosMax) ? PosMax : p + k;
  endfunction
  function automatic bit dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit alp(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit wrd(logic [7:0] b);
    return alp(b) || dig(b) || b == "_";
  endfunction

  function automatic void push_tok(kind_e k, op_e o, int v, int s, int l, bit last);
    tok_t t;
    t.kind = k; t.op = o; t.value = v[30:0]; t.start = s[15:0];
    t.len = l[15:0]; t.last = last;
    tok_q.push_back(t);
  endfunction

  function automatic void clear_model();
    held_n = 0; mode = MODE_IDLE; acc = 0; t_start = 0; t_len = 0; pos = 0;
    foreach (held_b[i]) held_b[i] = 8'h00;
  endfunction

  // -1 wait, 0 no, 1 yes
  function automatic int kw_match(string w, bit needs_end, logic [7:0] q[], int h, int n,
                                  bit fin);
    for (int i = 0; i < w.len(); i++) begin
      if (i >= n) return fin ? 0 : -1;
      if (q[h + i] != w[i]) return 0;
    end
    if (needs_end) begin
      if (n > w.len()) return wrd(q[h + w.len()]) ? 0 : 1;
      return fin ? 1 : -1;
    end
    return 1;
  endfunction

  function automatic void predict_word(logic [7:0] b, bit fin);
    logic [7:0] q[];
    int p[];
    int qn, h, n, r, cnt, s, sel;
    bit stop;
    op_e o;
    string kws[4];
    kws = '{"if", "else", "while", "return"};
    cnt = (mode == MODE_IDLE) ? held_n : 0;
    q = new[cnt + 1];
    p = new[cnt + 1];
    qn = 0;
    for (int i = 0; i < cnt; i++) begin
      q[qn] = held_b[i]; p[qn] = sat_add(t_start, i); qn++;
    end
    if (!fin) begin
      q[qn] = b; p[qn] = pos; qn++; pos = sat_add(pos, 1);
    end
    h = 0; stop = 0;
    while (h < qn && !stop) begin
      n = qn - h;
      if (mode == MODE_NUM) begin
        if (dig(q[h])) begin
          longint v;
          v = longint'(acc) * 10 + (q[h] - "0");
          acc = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(v);
          if (t_len < 65535) t_len++;
          h++;
        end else begin
          push_tok(KIND_NUM, OP_EQ, acc, t_start, t_len, 0); mode = MODE_IDLE;
        end
      end else if (mode == MODE_ID) begin
        if (q[h] inside {" ", ";", "+", "-", "*", "/", "(", ")", "<", ">", "=", "!"}) begin
          push_tok(KIND_ID, OP_EQ, 0, t_start, t_len, 0); mode = MODE_IDLE;
        end else if (q[h] inside {"@", ":", "$", "#", "&"}) begin
          push_tok(KIND_ILLEGAL, OP_EQ, 0, p[h], 0, 1); mode = MODE_ERR; h++;
        end else begin
          if (t_len < 65535) t_len++;
          h++;
        end
      end else if (mode == MODE_ERR) begin
        h++;
      end else if (q[h] == " " || (q[h] >= 8'd9 && q[h] <= 8'd13)) begin
        h++;
      end else if (q[h] inside {"=", "!", "<", ">"}) begin
        if (n < 2 && !fin) stop = 1;
        else if (n >= 2 && q[h + 1] == "=") begin
          o = q[h] == "=" ? OP_EQ : q[h] == "!" ? OP_NE : q[h] == "<" ? OP_LE : OP_GE;
          push_tok(KIND_OP, o, 0, p[h], 2, 0); h += 2;
        end else if (q[h] == "!") begin
          push_tok(KIND_INVALID, OP_EQ, 0, p[h], 0, 1); mode = MODE_ERR; h++;
        end else begin
          o = q[h] == "=" ? OP_ASSIGN : q[h] == "<" ? OP_LT : OP_GT;
          push_tok(KIND_OP, o, 0, p[h], 1, 0); h++;
        end
      end else if (q[h] inside {"+", "-", "*", "/", "(", ")", ";"}) begin
        o = q[h] == "+" ? OP_PLUS : q[h] == "-" ? OP_MINUS : q[h] == "*" ? OP_MUL :
            q[h] == "/" ? OP_DIV : q[h] == "(" ? OP_LPAR : q[h] == ")" ? OP_RPAR : OP_SEMI;
        push_tok(KIND_OP, o, 0, p[h], 1, 0); h++;
      end else if (dig(q[h])) begin
        mode = MODE_NUM; acc = q[h] - "0"; t_start = p[h]; t_len = 1; h++;
      end else if (alp(q[h]) || q[h] == "_") begin
        r = 0; sel = -1;
        for (int j = 0; j < 4; j++)
          if (sel < 0 && q[h] == kws[j][0]) begin
            sel = j; r = kw_match(kws[j], j == 3, q, h, n, fin);
          end
        if (r < 0) stop = 1;
        else if (r > 0) begin
          push_tok(kind_e'(KIND_IF + sel), OP_EQ, 0, p[h], kws[sel].len(), 0);
          h += kws[sel].len();
        end else begin
          mode = MODE_ID; t_start = p[h]; t_len = 1; h++;
        end
      end else begin
        push_tok(KIND_INVALID, OP_EQ, 0, p[h], 0, 1); mode = MODE_ERR; h++;
      end
    end
    held_n = 0;
    if (stop && mode == MODE_IDLE) begin
      s = qn - h;
      if (s > HoldDepth) s = HoldDepth;
      for (int i = 0; i < s; i++) held_b[i] = q[h + i];
      held_n = s;
      t_start = p[h];
    end
    if (fin) begin
      if (mode == MODE_NUM) push_tok(KIND_NUM, OP_EQ, acc, t_start, t_len, 0);
      else if (mode == MODE_ID) push_tok(KIND_ID, OP_EQ, 0, t_start, t_len, 0);
      if (mode != MODE_ERR) push_tok(KIND_END, OP_EQ, 0, pos, 0, 1);
      clear_model();
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hold valid high between back-to-back words, drop it only for a gap
  task automatic send_word(logic [7:0] b, bit fin);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    predict_word(b, fin);
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    end_mark_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic release_in();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    if (fin) send_word(8'h00, 1'b1);
  endtask

  task automatic drain();
    release_in();
    while (tok_q.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  // receiver with random stalls
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tok_t got, exp_t;
    n_cyc <= n_cyc + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {token_kind_o, operator_code_o, number_value_o, start_offset_o,
             token_length_o, run_last_o};
      if (tok_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected token %h", got);
      end else begin
        exp_t = tok_q.pop_front();
        if (got !== exp_t) begin
          n_err++;
          if (n_err <= 10)
            $display({"token mismatch: exp k%0d o%0d v%0d s%0d l%0d e%0b, ",
                      "got k%0d o%0d v%0d s%0d l%0d e%0b"},
                     exp_t.kind, exp_t.op, exp_t.value, exp_t.start, exp_t.len, exp_t.last,
                     got.kind, got.op, got.value, got.start, got.len, got.last);
        end
      end
    end
    if (n_cyc > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_operators();
    send_text("== != <= >= = + - * / ( ) < > ;<", 1'b1);
    send_text("a!=b", 1'b1);
    send_text("x !y", 1'b1);
  endtask

  task automatic test_keywords();
    send_text("if else while return returnx return; ifx whilst", 1'b1);
    send_text("return", 1'b1);
    send_text("whi", 1'b1);
  endtask

  task automatic test_numbers();
    send_text("0 2147483647 99999999999 12+3", 1'b1);
  endtask

  task automatic test_identifiers();
    send_text("_a\tb\nc foo_9", 1'b1);
    send_text("ab@cd ; zz", 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_hold_off();
    send_text("x=1", 1'b0);
    release_in();
    while (tok_q.size() != 0) @(negedge clk_i);
    send_text("<=", 1'b1);
  endtask

  task automatic test_random();
    string frags[] = '{"if", "else", "while", "return", "x", "_v", "ab1", "42", " ", " ",
                      "==", "!=", "<=", ">=", "=", "+", "-", "*", "/", "(", ")", ";",
                      "<", ">", "\t", "retur", "el", "wh", "i", "!"};
    int sent;
    int r;
    sent = 0;
    while (sent < 12) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        string f;
        f = frags[$urandom_range(0, frags.size() - 1)];
        send_text(f, 1'b0);
        sent += f.len();
      end else if (r < 92) begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
        sent++;
      end else begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
    send_word(8'h00, 1'b1);
  endtask

  initial begin
    clear_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_operators();
    test_keywords();
    test_numbers();
    test_identifiers();
    test_hold_off();
    test_random();
    drain();
    if (n_err == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
src/csl_pkg.sv
src/csl_step.sv
src/c_subset_lexer.sv
tb/tb_c_subset_lexer.sv
